[hdl/imhdk_pkg.sv]
// imhdk_pkg: shared types, field widths and controller command codes
// for the indexed min-heap decrease-key unit; used by every file in hdl
package imhdk_pkg;

  // fixed field widths of the request and result transactions
  localparam int ID_W  = 12;
  localparam int KEY_W = 32;
  localparam int CNT_W = 13;
  localparam int REQ_W = 2;

  // default configuration of the top level
  localparam int NUM_IDS_DEF  = 4096;
  localparam int KEY_BITS_DEF = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // status codes
  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_POP_EMPTY = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  item_id;
    logic [KEY_W-1:0] key_value;
  } in_t;

  typedef struct packed {
    logic             top_valid;
    logic [ID_W-1:0]  top_id;
    logic [KEY_W-1:0] top_key;
    logic [CNT_W-1:0] entry_count;
    logic             status;
  } out_t;

  // one datapath command per cycle
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_START,
    CMD_READ_SLOT,
    CMD_APPEND,
    CMD_READ_PARENT,
    CMD_MOVE_PARENT,
    CMD_PLACE,
    CMD_READ_KIDS,
    CMD_MOVE_CHILD,
    CMD_READ_LAST,
    CMD_POP_TAKE,
    CMD_CLEAR,
    CMD_POP_EMPTY
  } cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_clear;
    logic id_ok;
    logic count_zero;
    logic count_full;
    logic present;
    logic key_gt;
    logic pos_root;
    logic parent_gt;
    logic has_child;
    logic move_down;
    logic last_only;
  } dp_stat_t;

endpackage

[hdl/imhdk_dp.sv]
// imhdk_dp: heap slot memory, position memory, count and working registers
// depends on imhdk_pkg; driven by commands from imhdk_ctrl
module imhdk_dp #(
  parameter int NUM_IDS  = imhdk_pkg::NUM_IDS_DEF,
  parameter int KEY_BITS = imhdk_pkg::KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imhdk_pkg::cmd_t      cmd,
  input  imhdk_pkg::in_t       in_req,
  output imhdk_pkg::dp_stat_t  stat,
  output imhdk_pkg::out_t      result
);

  localparam int SW = $clog2(NUM_IDS + 1);
  localparam int IW = $clog2(NUM_IDS);
  localparam int IDW = imhdk_pkg::ID_W;
  localparam int REQ_W_L = imhdk_pkg::REQ_W;

  // heap slots (1..count used) and id-to-slot marks
  logic [IDW-1:0]      slot_id_mem [0:NUM_IDS];
  logic [KEY_BITS-1:0] slot_key_mem [0:NUM_IDS];
  logic [SW-1:0]       pos_mem [0:NUM_IDS-1];

  logic [REQ_W_L-1:0]  req_r;
  logic [IDW-1:0]      id_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SW-1:0]       pos_r;
  logic [SW-1:0]       count_r;
  logic [IDW-1:0]      root_id_r;
  logic [KEY_BITS-1:0] root_key_r;
  logic                status_r;

  logic [IDW-1:0]      rda_id_r, rdb_id_r;
  logic [KEY_BITS-1:0] rda_key_r, rdb_key_r;
  logic [SW-1:0]       pos_rd_r;

  logic [SW-1:0]       rda_addr, rdb_addr;
  logic [IW-1:0]       pos_raddr;
  logic                hw_en;
  logic [SW-1:0]       hw_addr;
  logic [IDW-1:0]      hw_id;
  logic [KEY_BITS-1:0] hw_key;
  logic                pw_en;
  logic [IW-1:0]       pw_addr;
  logic [SW-1:0]       pw_data;

  logic [SW:0]         child_l, child_r;
  logic                right_ok, pick_right;
  logic [SW-1:0]       child_pos;
  logic [IDW-1:0]      child_id;
  logic [KEY_BITS-1:0] child_key;

  // child selection for sift down
  always_comb begin
    child_l    = {pos_r, 1'b0};
    child_r    = {pos_r, 1'b1};
    right_ok   = child_r <= {1'b0, count_r};
    pick_right = right_ok && (rda_key_r > rdb_key_r);
    child_pos  = pick_right ? SW'(child_r) : SW'(child_l);
    child_id   = pick_right ? rdb_id_r : rda_id_r;
    child_key  = pick_right ? rdb_key_r : rda_key_r;
  end

  // read addresses and write commands
  always_comb begin
    pos_raddr = (cmd == imhdk_pkg::CMD_START) ? IW'(in_req.item_id) : IW'(id_r);
    rda_addr  = pos_r;
    rdb_addr  = pos_r;
    hw_en     = 1'b0;
    hw_addr   = pos_r;
    hw_id     = id_r;
    hw_key    = key_r;
    pw_en     = 1'b0;
    pw_addr   = IW'(id_r);
    pw_data   = pos_r;
    case (cmd)
      imhdk_pkg::CMD_READ_SLOT:   rda_addr = pos_rd_r;
      imhdk_pkg::CMD_READ_PARENT: rda_addr = pos_r >> 1;
      imhdk_pkg::CMD_READ_KIDS: begin
        rda_addr = SW'(child_l);
        rdb_addr = right_ok ? SW'(child_r) : SW'(child_l);
      end
      imhdk_pkg::CMD_READ_LAST:   rda_addr = count_r;
      imhdk_pkg::CMD_PLACE: begin
        hw_en = 1'b1;
        pw_en = 1'b1;
      end
      imhdk_pkg::CMD_MOVE_PARENT: begin
        hw_en   = 1'b1;
        hw_id   = rda_id_r;
        hw_key  = rda_key_r;
        pw_en   = 1'b1;
        pw_addr = IW'(rda_id_r);
      end
      imhdk_pkg::CMD_MOVE_CHILD: begin
        hw_en   = 1'b1;
        hw_id   = child_id;
        hw_key  = child_key;
        pw_en   = 1'b1;
        pw_addr = IW'(child_id);
      end
      imhdk_pkg::CMD_POP_TAKE: begin
        pw_en   = 1'b1;
        pw_addr = IW'(root_id_r);
        pw_data = '0;
      end
      default: ;
    endcase
  end

  // memories: one write port each, registered reads
  always_ff @(posedge clk) begin
    if (hw_en) begin
      slot_id_mem[hw_addr]  <= hw_id;
      slot_key_mem[hw_addr] <= hw_key;
    end
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    rda_id_r  <= slot_id_mem[rda_addr];
    rda_key_r <= slot_key_mem[rda_addr];
    rdb_id_r  <= slot_id_mem[rdb_addr];
    rdb_key_r <= slot_key_mem[rdb_addr];
    pos_rd_r  <= pos_mem[pos_raddr];
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      status_r <= imhdk_pkg::STAT_OK;
    end else begin
      if (hw_en && pos_r == SW'(1)) begin
        root_id_r  <= hw_id;
        root_key_r <= hw_key;
      end
      case (cmd)
        imhdk_pkg::CMD_START: begin
          req_r    <= in_req.req_type;
          id_r     <= in_req.item_id;
          key_r    <= KEY_BITS'(in_req.key_value);
          status_r <= imhdk_pkg::STAT_OK;
        end
        imhdk_pkg::CMD_READ_SLOT:   pos_r <= pos_rd_r;
        imhdk_pkg::CMD_APPEND: begin
          count_r <= count_r + SW'(1);
          pos_r   <= count_r + SW'(1);
        end
        imhdk_pkg::CMD_MOVE_PARENT: pos_r <= pos_r >> 1;
        imhdk_pkg::CMD_MOVE_CHILD:  pos_r <= child_pos;
        imhdk_pkg::CMD_POP_TAKE: begin
          id_r    <= rda_id_r;
          key_r   <= rda_key_r;
          count_r <= count_r - SW'(1);
          pos_r   <= SW'(1);
        end
        imhdk_pkg::CMD_CLEAR:     count_r  <= '0;
        imhdk_pkg::CMD_POP_EMPTY: status_r <= imhdk_pkg::STAT_POP_EMPTY;
        default: ;
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    stat.is_push    = req_r == imhdk_pkg::REQ_PUSH;
    stat.is_pop     = req_r == imhdk_pkg::REQ_POP;
    stat.is_clear   = req_r == imhdk_pkg::REQ_CLEAR;
    stat.id_ok      = 32'(id_r) < NUM_IDS;
    stat.count_zero = count_r == '0;
    stat.count_full = count_r == SW'(NUM_IDS);
    // a mark counts only if it points at a live slot holding this id
    stat.present    = (pos_r != '0) && (pos_r <= count_r) && (rda_id_r == id_r);
    stat.key_gt     = key_r > rda_key_r;
    stat.pos_root   = pos_r <= SW'(1);
    stat.parent_gt  = rda_key_r > key_r;
    stat.has_child  = child_l <= {1'b0, count_r};
    stat.move_down  = !(key_r < child_key);
    stat.last_only  = count_r == SW'(1);
  end

  // result transaction fields
  always_comb begin
    result.top_valid   = count_r != '0;
    result.top_id      = (count_r != '0) ? root_id_r : '0;
    result.top_key     = (count_r != '0) ? imhdk_pkg::KEY_W'(root_key_r) : '0;
    result.entry_count = imhdk_pkg::CNT_W'(count_r);
    result.status      = status_r;
  end

endmodule

[hdl/imhdk_ctrl.sv]
// imhdk_ctrl: sequencer for push, pop and clear over the heap datapath
// depends on imhdk_pkg; issues commands to imhdk_dp
module imhdk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  imhdk_pkg::dp_stat_t stat,
  output imhdk_pkg::cmd_t     cmd,
  output logic                busy,
  output logic                out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CLASSIFY, S_UP, S_UP_W,
    S_DOWN, S_DOWN_W, S_POP_W, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = imhdk_pkg::CMD_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd       = imhdk_pkg::CMD_START;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        if (stat.is_push) begin
          if (stat.id_ok) begin
            cmd       = imhdk_pkg::CMD_READ_SLOT;
            state_nxt = S_CLASSIFY;
          end
        end else if (stat.is_pop) begin
          if (stat.count_zero) begin
            cmd = imhdk_pkg::CMD_POP_EMPTY;
          end else begin
            cmd       = imhdk_pkg::CMD_READ_LAST;
            state_nxt = S_POP_W;
          end
        end else if (stat.is_clear) begin
          cmd = imhdk_pkg::CMD_CLEAR;
        end
      end
      S_CLASSIFY: begin
        if (stat.present) begin
          state_nxt = stat.key_gt ? S_DOWN : S_UP;
        end else if (stat.count_full) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = imhdk_pkg::CMD_APPEND;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (stat.pos_root) begin
          cmd       = imhdk_pkg::CMD_PLACE;
          state_nxt = S_DONE;
        end else begin
          cmd       = imhdk_pkg::CMD_READ_PARENT;
          state_nxt = S_UP_W;
        end
      end
      S_UP_W: begin
        if (stat.parent_gt) begin
          cmd       = imhdk_pkg::CMD_MOVE_PARENT;
          state_nxt = S_UP;
        end else begin
          cmd       = imhdk_pkg::CMD_PLACE;
          state_nxt = S_DONE;
        end
      end
      S_DOWN: begin
        if (stat.has_child) begin
          cmd       = imhdk_pkg::CMD_READ_KIDS;
          state_nxt = S_DOWN_W;
        end else begin
          cmd       = imhdk_pkg::CMD_PLACE;
          state_nxt = S_DONE;
        end
      end
      S_DOWN_W: begin
        if (stat.move_down) begin
          cmd       = imhdk_pkg::CMD_MOVE_CHILD;
          state_nxt = S_DOWN;
        end else begin
          cmd       = imhdk_pkg::CMD_PLACE;
          state_nxt = S_DONE;
        end
      end
      S_POP_W: begin
        cmd       = imhdk_pkg::CMD_POP_TAKE;
        state_nxt = stat.last_only ? S_DONE : S_DOWN;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_nxt == S_DONE) begin
      valid_nxt = 1'b1;
    end
  end

  // state and registered strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = valid_r;

endmodule

[hdl/indexed_min_heap_decrease_key_unit.sv]
// indexed_min_heap_decrease_key_unit: top level of the indexed min-heap
// depends on imhdk_pkg, imhdk_ctrl and imhdk_dp
//
// Usage:
//   A request transaction is taken at a clock edge with start high and busy
//   low. in_req carries req_type (push/update, pop, clear), item_id and
//   key_value. Every request yields one result transaction: out_valid is
//   high for exactly one cycle with out_result holding top_valid, top_id,
//   top_key, entry_count and status; it must be taken in that cycle, the
//   receiver has no way to stall it. busy stays high from acceptance until
//   the result cycle ends, so one request is worked at a time.
//   Steps: clear, pop on empty or out-of-range push go from dispatch
//   straight to the strobe, a push on a full heap passes classify first;
//   a push or pop then moves the entry level by level (one slot memory
//   read, one compare and write per level). The next request can start
//   the cycle after the strobe.
//   Reset (rst_n low, synchronous) empties the heap; no memory sweep is
//   needed because a position mark is trusted only if the slot it points
//   at is live and holds that id. Clear needs no sweep for the same
//   reason.
module indexed_min_heap_decrease_key_unit #(
  parameter int NUM_IDS  = imhdk_pkg::NUM_IDS_DEF,
  parameter int KEY_BITS = imhdk_pkg::KEY_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  imhdk_pkg::in_t  in_req,
  output logic            out_valid,
  output imhdk_pkg::out_t out_result
);

  imhdk_pkg::cmd_t     cmd;
  imhdk_pkg::dp_stat_t stat;

  // sequencer
  imhdk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // heap storage and working registers
  imhdk_dp #(
    .NUM_IDS  (NUM_IDS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .in_req (in_req),
    .stat   (stat),
    .result (out_result)
  );

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for indexed_min_heap_decrease_key_unit
// depends on imhdk_pkg and the hdl sources; carries its own heap predictor
`timescale 1ns / 1ps

module testbench;

  localparam int IDS = imhdk_pkg::NUM_IDS_DEF;
  localparam int IDW = imhdk_pkg::ID_W;
  localparam int KW  = imhdk_pkg::KEY_W;
  localparam int CW  = imhdk_pkg::CNT_W;
  localparam int RW  = imhdk_pkg::REQ_W;

  // request code with no function
  localparam logic [RW-1:0] REQ_SPARE = 2'd3;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  imhdk_pkg::in_t  in_req = '0;
  logic            out_valid;
  imhdk_pkg::out_t out_result;

  indexed_min_heap_decrease_key_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_result(out_result)
  );

  always #6 clk = ~clk;

  // predictor state: slots numbered from 1
  logic [IDW-1:0] slot_id  [1:IDS];
  logic [KW-1:0]  slot_key [1:IDS];
  int unsigned    pos_of   [0:IDS-1];
  int unsigned    held;

  imhdk_pkg::out_t expected_q[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   pops_empty = 0;
  int   max_held = 0;

  function automatic void put_slot(int unsigned p, logic [IDW-1:0] id, logic [KW-1:0] k);
    slot_id[p] = id;
    slot_key[p] = k;
    pos_of[id] = p;
  endfunction

  function automatic void bubble_up(int unsigned p, logic [IDW-1:0] id, logic [KW-1:0] k);
    while (p > 1 && slot_key[p/2] > k) begin
      put_slot(p, slot_id[p/2], slot_key[p/2]);
      p = p / 2;
    end
    put_slot(p, id, k);
  endfunction

  function automatic void bubble_down(int unsigned p, logic [IDW-1:0] id, logic [KW-1:0] k);
    int unsigned c;
    c = 2 * p;
    while (c <= held) begin
      if (c + 1 <= held && slot_key[c] > slot_key[c+1]) c++;
      if (k < slot_key[c]) break;
      put_slot(p, slot_id[c], slot_key[c]);
      p = c;
      c = 2 * p;
    end
    put_slot(p, id, k);
  endfunction

  // apply one request to the predictor and return the answer it gives
  function automatic imhdk_pkg::out_t heap_answer(imhdk_pkg::in_t r);
    imhdk_pkg::out_t o;
    int unsigned p;
    logic [IDW-1:0] gone;
    o = '0;
    o.status = imhdk_pkg::STAT_OK;
    if (r.req_type == imhdk_pkg::REQ_PUSH) begin
      p = pos_of[r.item_id];
      if (p == 0 || p > held) begin
        if (held < IDS) begin
          held++;
          bubble_up(held, r.item_id, r.key_value);
        end
      end else if (r.key_value > slot_key[p]) begin
        bubble_down(p, r.item_id, r.key_value);
      end else begin
        bubble_up(p, r.item_id, r.key_value);
      end
    end else if (r.req_type == imhdk_pkg::REQ_POP) begin
      if (held == 0) begin
        o.status = imhdk_pkg::STAT_POP_EMPTY;
      end else begin
        gone = slot_id[1];
        held--;
        pos_of[gone] = 0;
        if (held > 0) bubble_down(1, slot_id[held+1], slot_key[held+1]);
      end
    end else if (r.req_type == imhdk_pkg::REQ_CLEAR) begin
      foreach (pos_of[i]) pos_of[i] = 0;
      held = 0;
    end
    if (held > 0) begin
      o.top_valid = 1'b1;
      o.top_id = slot_id[1];
      o.top_key = slot_key[1];
    end
    o.entry_count = held[CW-1:0];
    if (held > max_held) max_held = held;
    return o;
  endfunction

  // result checker: every strobe is compared with the oldest expectation
  always @(posedge clk) begin
    imhdk_pkg::out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_result);
      end else begin
        want = expected_q.pop_front();
        if (want.status == imhdk_pkg::STAT_POP_EMPTY) pops_empty++;
        if (out_result.top_valid !== want.top_valid || out_result.top_id !== want.top_id ||
            out_result.top_key !== want.top_key ||
            out_result.entry_count !== want.entry_count ||
            out_result.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %p actual %p", results_seen, want, out_result);
        end
      end
    end
  end

  // directed rows; fixed answers only where obvious, zero check flag uses predictor
  typedef struct {
    imhdk_pkg::in_t  req;
    logic            fixed;
    imhdk_pkg::out_t ans;
  } row_t;

  function automatic imhdk_pkg::out_t mk_ans(logic v, logic [IDW-1:0] id, logic [KW-1:0] k,
                                             logic [CW-1:0] n, logic s);
    imhdk_pkg::out_t o;
    o.top_valid = v; o.top_id = id; o.top_key = k; o.entry_count = n; o.status = s;
    return o;
  endfunction

  function automatic imhdk_pkg::in_t mk_req(logic [RW-1:0] t, logic [IDW-1:0] id,
                                            logic [KW-1:0] k);
    imhdk_pkg::in_t r;
    r.req_type = t; r.item_id = id; r.key_value = k;
    return r;
  endfunction

  task automatic send_transaction(imhdk_pkg::in_t r, logic fixed, imhdk_pkg::out_t ans);
    imhdk_pkg::out_t pred;
    int unsigned     gap;
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = heap_answer(r);
    expected_q.push_back(fixed ? ans : pred);
    // random gap, mostly none or short, sometimes long
    gap = 0;
    if ($urandom_range(0, 9) >= 6) begin
      if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 60);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  row_t           rows[$];
  int             rnd_items;
  int             pool;
  int             pick;
  imhdk_pkg::in_t r;

  initial begin
    held = 0;
    foreach (pos_of[i]) pos_of[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, 12'hFFF, '1), 1'b1,
                     mk_ans(1'b0, '0, '0, '0, imhdk_pkg::STAT_POP_EMPTY)});
    rows.push_back('{mk_req(imhdk_pkg::REQ_CLEAR, '0, '0), 1'b1,
                     mk_ans(1'b0, '0, '0, '0, imhdk_pkg::STAT_OK)});
    rows.push_back('{mk_req(REQ_SPARE, 12'hABC, 32'h1234), 1'b1,
                     mk_ans(1'b0, '0, '0, '0, imhdk_pkg::STAT_OK)});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'hFFF, 32'hFFFF_FFFF), 1'b1,
                     mk_ans(1'b1, 12'hFFF, 32'hFFFF_FFFF, 13'd1, imhdk_pkg::STAT_OK)});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h000, 32'h0000_0000), 1'b1,
                     mk_ans(1'b1, 12'h000, '0, 13'd2, imhdk_pkg::STAT_OK)});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h555, 32'd50), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'hAAA, 32'd50), 1'b0, '0});  // equal keys
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h123, 32'd70), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h123, 32'd10), 1'b0, '0});  // decrease key
    // increase key on root
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h000, 32'd90), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h555, 32'd50), 1'b0, '0});  // same key again
    rows.push_back('{mk_req(REQ_SPARE, 12'h001, 32'd1), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, '0, '0), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, '0, '0), 1'b0, '0});
    // re-push of popped id
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h123, 32'd5), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, '0, '0), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, '0, '0), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, '0, '0), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, '0, '0), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_POP, '0, '0), 1'b1,
                     mk_ans(1'b0, '0, '0, '0, imhdk_pkg::STAT_POP_EMPTY)});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h7FF, 32'h8000_0000), 1'b0, '0});
    rows.push_back('{mk_req(imhdk_pkg::REQ_CLEAR, '0, '0), 1'b1,
                     mk_ans(1'b0, '0, '0, '0, imhdk_pkg::STAT_OK)});
    rows.push_back('{mk_req(imhdk_pkg::REQ_PUSH, 12'h7FF, 32'h7FFF_FFFF), 1'b1,
                     mk_ans(1'b1, 12'h7FF, 32'h7FFF_FFFF, 13'd1, imhdk_pkg::STAT_OK)});
    foreach (rows[i]) send_transaction(rows[i].req, rows[i].fixed, rows[i].ans);

    // hold off until every answer is back
    drain_results();

    // random part: phases with different id pools
    rnd_items = 0;
    while (rnd_items < 950) begin
      pool = (rnd_items / 150) % 3 == 0 ? 15 : ((rnd_items / 150) % 3 == 1 ? 255 : 4095);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        r = mk_req(imhdk_pkg::REQ_PUSH, IDW'($urandom_range(0, pool)), $urandom);
        if ($urandom_range(0, 3) == 0) r.key_value = $urandom_range(0, 31);
      end else if (pick < 95) begin
        r = mk_req(imhdk_pkg::REQ_POP, IDW'($urandom), $urandom);
      end else if (pick < 98) begin
        r = mk_req(imhdk_pkg::REQ_CLEAR, IDW'($urandom), $urandom);
      end else begin
        r = mk_req(REQ_SPARE, IDW'($urandom), $urandom);
      end
      send_transaction(r, 1'b0, '0);
      rnd_items++;
      if (rnd_items % 300 == 0) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("covered %0d directed and %0d random requests; %0d results, %0d empty pops,",
             rows.size(), rnd_items, results_seen, pops_empty);
    $display("deepest heap held %0d entries, %0d mismatches", max_held, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
